// ===== sv/hbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbsc_pkg
// shared types, constants and the usage-to-scancode table for the boot
// keyboard report to set 1 converter
// ----------------------------------------------------------------------------
package hbsc_pkg;

	localparam logic [7:0] PREFIX_EXT     = 8'hE0;
	localparam logic [7:0] BREAK_BIT      = 8'h80;
	localparam logic [7:0] ROLLOVER_USAGE = 8'h01;
	localparam logic [7:0] LAST_RESERVED  = 8'h03;
	localparam logic [7:0] USAGE_LIMIT    = 8'h74;

	// event queue depth between scanner and byte sender
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// modifier bits 0..7: make code and prefix flag
	localparam logic [6:0] MOD_CODE [8] = '{
		7'h1D, 7'h2A, 7'h38, 7'h5B, 7'h1D, 7'h36, 7'h38, 7'h5C
	};
	localparam logic [7:0] MOD_EXT = 8'hD8;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_SCAN,
		FS_FLUSH
	} front_state_t;

	// one key event: prefix flag, make or break byte, end of report
	typedef struct packed {
		logic       ext;
		logic [7:0] code;
		logic       last;
	} evt_t;

	typedef struct packed {
		logic       hit;
		logic       ext;
		logic [6:0] code;
	} key_map_t;

	function automatic key_map_t key_map(input logic [7:0] usage);
		logic [6:0] pc;
		logic [6:0] ec;
		key_map_t   m;
		pc = 7'h00;
		ec = 7'h00;
		case (usage)
			8'h04: pc = 7'h1E; 8'h05: pc = 7'h30; 8'h06: pc = 7'h2E; 8'h07: pc = 7'h20;
			8'h08: pc = 7'h12; 8'h09: pc = 7'h21; 8'h0A: pc = 7'h22; 8'h0B: pc = 7'h23;
			8'h0C: pc = 7'h17; 8'h0D: pc = 7'h24; 8'h0E: pc = 7'h25; 8'h0F: pc = 7'h26;
			8'h10: pc = 7'h32; 8'h11: pc = 7'h31; 8'h12: pc = 7'h18; 8'h13: pc = 7'h19;
			8'h14: pc = 7'h10; 8'h15: pc = 7'h13; 8'h16: pc = 7'h1F; 8'h17: pc = 7'h14;
			8'h18: pc = 7'h16; 8'h19: pc = 7'h2F; 8'h1A: pc = 7'h11; 8'h1B: pc = 7'h2D;
			8'h1C: pc = 7'h15; 8'h1D: pc = 7'h2C; 8'h1E: pc = 7'h02; 8'h1F: pc = 7'h03;
			8'h20: pc = 7'h04; 8'h21: pc = 7'h05; 8'h22: pc = 7'h06; 8'h23: pc = 7'h07;
			8'h24: pc = 7'h08; 8'h25: pc = 7'h09; 8'h26: pc = 7'h0A; 8'h27: pc = 7'h0B;
			8'h28: pc = 7'h1C; 8'h29: pc = 7'h01; 8'h2A: pc = 7'h0E; 8'h2B: pc = 7'h0F;
			8'h2C: pc = 7'h39; 8'h2D: pc = 7'h0C; 8'h2E: pc = 7'h0D; 8'h2F: pc = 7'h1A;
			8'h30: pc = 7'h1B; 8'h31: pc = 7'h2B; 8'h33: pc = 7'h27; 8'h34: pc = 7'h28;
			8'h35: pc = 7'h29; 8'h36: pc = 7'h33; 8'h37: pc = 7'h34; 8'h38: pc = 7'h35;
			8'h39: pc = 7'h3A; 8'h3A: pc = 7'h3B; 8'h3B: pc = 7'h3C; 8'h3C: pc = 7'h3D;
			8'h3D: pc = 7'h3E; 8'h3E: pc = 7'h3F; 8'h3F: pc = 7'h40; 8'h40: pc = 7'h41;
			8'h41: pc = 7'h42; 8'h42: pc = 7'h43; 8'h43: pc = 7'h44; 8'h44: pc = 7'h57;
			8'h45: pc = 7'h58;
			default: pc = 7'h00;
		endcase
		case (usage)
			8'h46: ec = 7'h37; 8'h49: ec = 7'h52; 8'h4A: ec = 7'h47; 8'h4B: ec = 7'h49;
			8'h4C: ec = 7'h53; 8'h4D: ec = 7'h4F; 8'h4E: ec = 7'h51; 8'h4F: ec = 7'h4D;
			8'h50: ec = 7'h4B; 8'h51: ec = 7'h50; 8'h52: ec = 7'h48; 8'h58: ec = 7'h1C;
			default: ec = 7'h00;
		endcase
		if (pc != 7'h00) begin
			m = '{hit: 1'b1, ext: 1'b0, code: pc};
		end else if (ec != 7'h00) begin
			m = '{hit: 1'b1, ext: 1'b1, code: ec};
		end else begin
			m = '{hit: 1'b0, ext: 1'b0, code: 7'h00};
		end
		return m;
	endfunction

endpackage

// ===== sv/hbsc_front.sv =====
// ----------------------------------------------------------------------------
// hbsc_front
// accepts reports, drops short and rollover ones, and scans modifier bits, old
// slots and new slots one step a cycle unless the queue is full, queueing key events
// ----------------------------------------------------------------------------
module hbsc_front #(
	parameter int KEY_SLOTS = 6,
	parameter int IN_W      = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,
	output logic               push,
	output hbsc_pkg::evt_t     push_data,
	input  logic               q_full
);

	localparam int NSTEP  = 8 + 2 * KEY_SLOTS;
	localparam int STEP_W = $clog2(NSTEP);
	localparam logic [4:0] MIN_LEN = 5'(2 + KEY_SLOTS);

	hbsc_pkg::front_state_t state_q, state_nx;

	logic [STEP_W-1:0] step_q;
	logic [7:0]        mods_q;
	logic [7:0]        prev_mods_q;
	logic [7:0]        cur_keys_q  [KEY_SLOTS];
	logic [7:0]        prev_keys_q [KEY_SLOTS];
	logic              pend_valid_q;
	logic              pend_ext_q;
	logic [7:0]        pend_code_q;

	logic [3:0]        in_len;
	logic [7:0]        in_mods;
	logic [7:0]        in_keys [KEY_SLOTS];
	logic              in_roll;
	logic              in_drop;
	logic              in_take;

	logic              ev;
	logic              ev_ext;
	logic [7:0]        ev_code;
	logic              last_step;
	logic              advance;
	logic              flush_done;

	// unpack the report
	always_comb begin
		in_len  = s_tdata[3:0];
		in_mods = s_tdata[11:4];
		in_roll = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			in_keys[i] = s_tdata[12 + 8 * i +: 8];
			if (in_keys[i] == hbsc_pkg::ROLLOVER_USAGE) begin
				in_roll = 1'b1;
			end
		end
		in_drop = ({1'b0, in_len} < MIN_LEN) || in_roll;
	end

	// event for the current scan step
	always_comb begin
		logic [7:0]          u;
		logic                is_rel;
		logic                present;
		logic [2:0]          bi;
		hbsc_pkg::key_map_t  m;
		u       = 8'h00;
		is_rel  = 1'b0;
		present = 1'b0;
		bi      = step_q[2:0];
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (step_q == STEP_W'(8 + i)) begin
				u      = prev_keys_q[i];
				is_rel = 1'b1;
			end
			if (step_q == STEP_W'(8 + KEY_SLOTS + i)) begin
				u = cur_keys_q[i];
			end
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (is_rel && cur_keys_q[i] == u) begin
				present = 1'b1;
			end
			if (!is_rel && prev_keys_q[i] == u) begin
				present = 1'b1;
			end
		end
		m = hbsc_pkg::key_map(u);
		if (step_q < STEP_W'(8)) begin
			ev      = mods_q[bi] ^ prev_mods_q[bi];
			ev_ext  = hbsc_pkg::MOD_EXT[bi];
			ev_code = {~mods_q[bi], hbsc_pkg::MOD_CODE[bi]};
		end else begin
			ev      = (u > hbsc_pkg::LAST_RESERVED) && !present && m.hit;
			ev_ext  = m.ext;
			ev_code = {is_rel, m.code};
		end
	end

	assign last_step = (step_q == STEP_W'(NSTEP - 1));

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			hbsc_pkg::FS_IDLE: begin
				if (s_tvalid && !in_drop) begin
					state_nx = hbsc_pkg::FS_SCAN;
				end
			end
			hbsc_pkg::FS_SCAN: begin
				if (advance && last_step) begin
					state_nx = hbsc_pkg::FS_FLUSH;
				end
			end
			hbsc_pkg::FS_FLUSH: begin
				if (flush_done) begin
					state_nx = hbsc_pkg::FS_IDLE;
				end
			end
			default: state_nx = hbsc_pkg::FS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready   = 1'b0;
		advance    = 1'b0;
		flush_done = 1'b0;
		push       = 1'b0;
		push_data  = '{ext: pend_ext_q, code: pend_code_q, last: 1'b0};
		case (state_q)
			hbsc_pkg::FS_IDLE: begin
				s_tready = 1'b1;
			end
			hbsc_pkg::FS_SCAN: begin
				advance = !(ev && pend_valid_q && q_full);
				push    = advance && ev && pend_valid_q;
			end
			hbsc_pkg::FS_FLUSH: begin
				flush_done     = !pend_valid_q || !q_full;
				push           = pend_valid_q && !q_full;
				push_data.last = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign in_take = s_tvalid && s_tready && !in_drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hbsc_pkg::FS_IDLE;
			step_q       <= '0;
			pend_valid_q <= 1'b0;
			prev_mods_q  <= 8'h00;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_keys_q[i] <= 8'h00;
			end
		end else begin
			state_q <= state_nx;
			if (in_take) begin
				step_q <= '0;
			end else if (advance) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (advance && ev) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == hbsc_pkg::FS_FLUSH && flush_done) begin
				pend_valid_q <= 1'b0;
			end
			if (advance && last_step) begin
				prev_mods_q <= mods_q;
				for (int i = 0; i < KEY_SLOTS; i++) begin
					prev_keys_q[i] <= cur_keys_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mods_q <= in_mods;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				cur_keys_q[i] <= in_keys[i];
			end
		end
		if (advance && ev) begin
			pend_ext_q  <= ev_ext;
			pend_code_q <= ev_code;
		end
	end

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("event pushed into a full queue");

	a_prev_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != hbsc_pkg::FS_SCAN) |=> $stable(prev_mods_q))
		else $error("previous modifiers changed outside a scan");

endmodule

// ===== sv/hbsc_queue.sv =====
// ----------------------------------------------------------------------------
// hbsc_queue
// short event queue between the scanner and the byte sender
// ----------------------------------------------------------------------------
module hbsc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hbsc_pkg::evt_t push_data,
	output logic           full,
	input  logic           pop,
	output hbsc_pkg::evt_t pop_data,
	output logic           empty
);

	hbsc_pkg::evt_t                mem_q [hbsc_pkg::QDEPTH];
	logic [hbsc_pkg::QPTR_W-1:0]   wr_q;
	logic [hbsc_pkg::QPTR_W-1:0]   rd_q;
	logic [hbsc_pkg::QCNT_W-1:0]   cnt_q;

	assign full     = (cnt_q == hbsc_pkg::QCNT_W'(hbsc_pkg::QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + hbsc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + hbsc_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + hbsc_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - hbsc_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from an empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= hbsc_pkg::QCNT_W'(hbsc_pkg::QDEPTH))
		else $error("queue count beyond depth");

endmodule

// ===== sv/hbsc_back.sv =====
// ----------------------------------------------------------------------------
// hbsc_back
// turns queued key events into scancode words, inserting the e0 prefix,
// behind a registered output stage
// ----------------------------------------------------------------------------
module hbsc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  hbsc_pkg::evt_t pop_data,
	input  logic           empty,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic           m_tlast
);

	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;
	logic       hold_valid_q;
	logic [7:0] hold_code_q;
	logic       hold_last_q;
	logic       out_load;

	assign out_load = !out_valid_q || m_tready;
	assign pop      = out_load && !hold_valid_q && !empty;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (out_load) begin
			if (hold_valid_q) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= 1'b0;
			end else if (!empty) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= pop_data.ext;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (hold_valid_q) begin
				out_data_q <= hold_code_q;
				out_last_q <= hold_last_q;
			end else if (pop_data.ext) begin
				out_data_q  <= hbsc_pkg::PREFIX_EXT;
				out_last_q  <= 1'b0;
				hold_code_q <= pop_data.code;
				hold_last_q <= pop_data.last;
			end else begin
				out_data_q <= pop_data.code;
				out_last_q <= pop_data.last;
			end
		end
	end

	a_prefix_first: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> (out_valid_q && out_data_q == hbsc_pkg::PREFIX_EXT && !out_last_q))
		else $error("held code byte without a prefix on the output");

endmodule

// ===== sv/hid_boot_report_to_set1_scancodes_core.sv =====
// ----------------------------------------------------------------------------
// hid_boot_report_to_set1_scancodes_core
// usb hid boot keyboard report to ps/2 scancode set 1 converter
// ----------------------------------------------------------------------------
// One boot keyboard report comes in per slave word and is compared with the
// last report that was kept. Reports with a length below 2 + KEY_SLOTS, or
// holding the rollover usage, are taken and dropped without output or state
// change. For any other report the block sends set 1 words in this order:
// modifier changes from bit 0 to bit 7, releases of old usages above 0x03
// that are gone, then presses of new usages above 0x03; a release is the make
// code with bit 7 set, and extended keys are led by an e0 word. Usages with
// no set 1 entry send nothing but are kept as state. The final word of a
// report carries tlast; a report with no change sends nothing. The front
// scanner accepts a report and then takes one cycle per scan step, 8 + 2 *
// KEY_SLOTS steps plus one to close the report, and accepts no new report
// until that one is closed. The scanner stalls only when the four-entry
// event queue is full, and the sender drives one word per cycle whenever
// the master side is ready. State clears at reset.
// ----------------------------------------------------------------------------
module hid_boot_report_to_set1_scancodes_core #(
	parameter int KEY_SLOTS = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	// report in
	input  logic             s_tvalid,
	output logic             s_tready,
	// report_length[3:0], modifier_bits[11:4], key_usage_i at 12 + 8*i, zero pad
	input  logic [((12 + 8 * KEY_SLOTS + 7) / 8) * 8 - 1:0] s_tdata,
	// scancode out
	output logic             m_tvalid,
	input  logic             m_tready,
	// scancode_byte[7:0]
	output logic [7:0]       m_tdata,
	// last_of_run
	output logic             m_tlast
);

	localparam int IN_W = ((12 + 8 * KEY_SLOTS + 7) / 8) * 8;

	// key events between scanner and sender
	logic           push;
	hbsc_pkg::evt_t push_data;
	logic           q_full;
	logic           pop;
	hbsc_pkg::evt_t pop_data;
	logic           q_empty;

	// front: accept, drop check, per-step diff against kept state
	hbsc_front #(
		.KEY_SLOTS (KEY_SLOTS),
		.IN_W      (IN_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// queue lets the scanner run ahead while words drain
	hbsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	// back: prefix insertion and registered output word
	hbsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.empty    (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the boot keyboard report to set 1 scancode core
// ----------------------------------------------------------------------------
// Boot keyboard reports are pushed into the slave side and the set 1 words
// that come out of the master side are compared with an independent
// prediction. A short directed list covers these cases:
//   - every modifier bit pressed and released
//   - the ends of the plain and extended key ranges
//   - unmapped and reserved usages
//   - short reports, rollover reports and repeated reports
//   - lengths past eight and usages held in two slots
//   - the longest burst of output for one report
// A long random phase follows. It is mostly realistic keystroke sequences,
// with some short, rollover and pure noise reports mixed in. Both sides
// insert random idle bursts. Once the sink holds off long enough for the
// core to back up, and once the source stops until every expected word has
// come out.
// ----------------------------------------------------------------------------

localparam int KEY_SLOTS = 6;

// one expected output word
typedef struct packed {
	logic [7:0] code;
	logic       last;
} set1_word_t;

// keeps the key state seen by the core and the words still owed by it
class scancode_board;
	logic [7:0]                  held_mods;
	logic [KEY_SLOTS-1:0][7:0]   held_keys;
	set1_word_t                  expected_words [$];
	logic [7:0]                  run_codes [$];
	logic [7:0]                  plain_make [66];
	logic [7:0]                  ext_make [19];
	logic [7:0]                  mod_make [8];
	logic [7:0]                  mod_prefixed;
	int                          reports_kept;
	int                          reports_dropped;
	int                          words_checked;
	int                          failures;

	function new();
		held_mods = 8'h00;
		held_keys = '0;
		// usages 0x04..0x45
		plain_make = '{
			8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23,
			8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19,
			8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D,
			8'h15, 8'h2C, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
			8'h08, 8'h09, 8'h0A, 8'h0B, 8'h1C, 8'h01, 8'h0E, 8'h0F,
			8'h39, 8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h2B, 8'h00, 8'h27,
			8'h28, 8'h29, 8'h33, 8'h34, 8'h35, 8'h3A, 8'h3B, 8'h3C,
			8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44,
			8'h57, 8'h58
		};
		// usages 0x46..0x58, sent behind the e0 prefix
		ext_make = '{
			8'h37, 8'h00, 8'h00, 8'h52, 8'h47, 8'h49, 8'h53, 8'h4F,
			8'h51, 8'h4D, 8'h4B, 8'h50, 8'h48, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h1C
		};
		mod_make = '{8'h1D, 8'h2A, 8'h38, 8'h5B, 8'h1D, 8'h36, 8'h38, 8'h5C};
		// super keys and the right ctrl and alt need the prefix
		mod_prefixed = 8'b1101_1000;
		reports_kept = 0;
		reports_dropped = 0;
		words_checked = 0;
		failures = 0;
	endfunction

	function bit slot_has(logic [KEY_SLOTS-1:0][7:0] keys, logic [7:0] usage);
		for (int i = 0; i < KEY_SLOTS; i++)
			if (keys[i] == usage)
				return 1'b1;
		return 1'b0;
	endfunction

	// appends the words for one key going down or up, if it has a set 1 code
	function void add_key(logic [7:0] usage, bit released);
		logic [7:0] make;
		bit         prefixed;
		make = 8'h00;
		prefixed = 1'b0;
		if (usage >= 8'h04 && usage <= 8'h45)
			make = plain_make[usage - 8'h04];
		if (make == 8'h00 && usage >= 8'h46 && usage <= 8'h58) begin
			make = ext_make[usage - 8'h46];
			prefixed = 1'b1;
		end
		if (make == 8'h00)
			return;
		if (prefixed)
			run_codes.push_back(hbsc_pkg::PREFIX_EXT);
		run_codes.push_back(released ? (make | hbsc_pkg::BREAK_BIT) : make);
	endfunction

	// called for each report the core takes
	function void note_report(logic [63:0] word);
		logic [7:0]                mods;
		logic [7:0]                changed;
		logic [KEY_SLOTS-1:0][7:0] keys;
		if (word[3:0] < 4'd8) begin
			reports_dropped++;
			return;
		end
		mods = word[11:4];
		keys = word[12 +: 8*KEY_SLOTS];
		for (int i = 0; i < KEY_SLOTS; i++)
			if (keys[i] == hbsc_pkg::ROLLOVER_USAGE) begin
				reports_dropped++;
				return;
			end
		run_codes.delete();
		changed = mods ^ held_mods;
		for (int b = 0; b < 8; b++)
			if (changed[b]) begin
				if (mod_prefixed[b])
					run_codes.push_back(hbsc_pkg::PREFIX_EXT);
				run_codes.push_back(mods[b] ? mod_make[b]
					: (mod_make[b] | hbsc_pkg::BREAK_BIT));
			end
		for (int i = 0; i < KEY_SLOTS; i++)
			if (held_keys[i] > hbsc_pkg::LAST_RESERVED && !slot_has(keys, held_keys[i]))
				add_key(held_keys[i], 1'b1);
		for (int i = 0; i < KEY_SLOTS; i++)
			if (keys[i] > hbsc_pkg::LAST_RESERVED && !slot_has(held_keys, keys[i]))
				add_key(keys[i], 1'b0);
		held_mods = mods;
		held_keys = keys;
		reports_kept++;
		foreach (run_codes[n])
			expected_words.push_back(set1_word_t'{run_codes[n], n == run_codes.size() - 1});
	endfunction

	// called for each word the core hands over
	function void check_word(logic [7:0] code, logic last);
		set1_word_t want;
		words_checked++;
		if (expected_words.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("error: word %h last %b arrived with none pending", code, last);
			return;
		end
		want = expected_words.pop_front();
		if (want.code !== code || want.last !== last) begin
			failures++;
			if (failures <= 10)
				$display("error: word %0d expected %h last %b, got %h last %b",
					words_checked, want.code, want.last, code, last);
		end
	endfunction
endclass

module tb_top;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [63:0]               s_tdata;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [7:0]                m_tdata;
	logic                      m_tlast;

	scancode_board             board;

	// idle bursts on the source and sink side, off near the end
	bit                        src_jitter = 1'b1;
	bit                        sink_jitter = 1'b1;
	// source asks the sink for one long hold-off
	bit                        hold_request = 1'b0;
	int                        sink_stall;
	int                        hold_left;

	// key state the random keystroke generator builds on
	logic [7:0]                gen_mods;
	logic [KEY_SLOTS-1:0][7:0] gen_keys;

	hid_boot_report_to_set1_scancodes_core #(
		.KEY_SLOTS(KEY_SLOTS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the core hangs
	initial begin
		#15_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [KEY_SLOTS-1:0][7:0] keys6(input logic [7:0] k0, k1, k2,
			k3, k4, k5);
		return {k5, k4, k3, k2, k1, k0};
	endfunction

	// mostly mapped usages, some empty slots, now and then anything but rollover
	function automatic logic [7:0] pick_usage();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return 8'h00;
		if (r < 80)
			return 8'($urandom_range(8'h04, 8'h58));
		if (r < 88)
			return 8'($urandom_range(2, 3));
		return 8'($urandom_range(2, 255));
	endfunction

	// drop valid for a number of cycles, with junk on the data lines
	task automatic pause_source(input int cycles);
		s_tvalid <= 1'b0;
		s_tdata <= {$urandom, $urandom};
		repeat (cycles) @(posedge clk);
	endtask

	// offer one report word and wait for the core to take it
	task automatic send_report(input logic [3:0] len, input logic [7:0] mods,
			input logic [KEY_SLOTS-1:0][7:0] keys);
		logic [63:0] word;
		word = {4'h0, keys, mods, len};
		if (src_jitter && $urandom_range(0, 5) == 0)
			pause_source($urandom_range(1, 10));
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		board.note_report(word);
	endtask

	// hold the source until every owed word has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.expected_words.size() != 0) @(posedge clk);
	endtask

	// one random report: mostly the next step of a typing sequence,
	// otherwise short, rollover or pure noise
	task automatic random_report();
		int                        kind;
		logic [3:0]                len;
		logic [7:0]                mods;
		logic [KEY_SLOTS-1:0][7:0] keys;
		kind = $urandom_range(0, 99);
		len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
		mods = gen_mods;
		keys = gen_keys;
		if ($urandom_range(0, 2) == 0)
			mods[$urandom_range(0, 7)] = ~mods[$urandom_range(0, 7)];
		if ($urandom_range(0, 9) == 0)
			mods = 8'($urandom);
		for (int i = 0; i < KEY_SLOTS; i++)
			if ($urandom_range(0, 3) == 0)
				keys[i] = pick_usage();
		if (kind < 8) begin
			len = 4'($urandom_range(0, 7));
		end else if (kind < 13) begin
			keys[$urandom_range(0, KEY_SLOTS - 1)] = hbsc_pkg::ROLLOVER_USAGE;
		end else if (kind < 18) begin
			len = 4'($urandom);
			mods = 8'($urandom);
			keys = {$urandom, 16'($urandom)};
		end
		send_report(len, mods, keys);
		gen_mods = board.held_mods;
		gen_keys = board.held_keys;
	endtask

	// sink: checks every word taken, then picks tready for the next cycle
	initial begin
		m_tready <= 1'b0;
		sink_stall = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check_word(m_tdata, m_tlast);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 400;
			end
			if (sink_stall == 0 && sink_jitter && $urandom_range(0, 7) == 0)
				sink_stall = $urandom_range(1, 10);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_stall > 0) begin
				sink_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// source: reset, directed reports, then the random phase
	initial begin
		board = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		gen_mods = 8'h00;
		gen_keys = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every modifier down, then every modifier up
		send_report(4'd8, 8'hFF, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(4'd8, 8'h00, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		// ends of the plain and extended ranges, a hole and a high unmapped usage
		send_report(4'd8, 8'h55, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04));
		send_report(4'd8, 8'hAA, keys6(8'h45, 8'h46, 8'h58, 8'h32, 8'h73, 8'h04));
		// release into unmapped, reserved and empty slots
		send_report(4'd8, 8'hAA, keys6(8'h74, 8'hFF, 8'h02, 8'h03, 8'h00, 8'h53));
		// short reports are dropped whatever they carry
		send_report(4'd7, 8'h00, keys6(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
		send_report(4'd0, 8'h0F, keys6(8'h49, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		// rollover report is dropped
		send_report(4'd8, 8'h0F, keys6(8'h01, 8'h04, 8'h49, 8'h00, 8'h00, 8'h00));
		send_report(4'd8, 8'hAA, keys6(8'h02, 8'h03, 8'h04, 8'h05, 8'h01, 8'h01));
		// same as the kept state: nothing comes out
		send_report(4'd8, 8'hAA, keys6(8'h74, 8'hFF, 8'h02, 8'h03, 8'h00, 8'h53));
		// overlong report with a key held in two slots each
		send_report(4'd15, 8'h00, keys6(8'h04, 8'h04, 8'h49, 8'h49, 8'h00, 8'h00));
		send_report(4'd8, 8'h00, keys6(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(4'd8, 8'h00, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		// longest run: all modifiers and six extended keys change at once
		send_report(4'd8, 8'h00, keys6(8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E));
		send_report(4'd8, 8'hFF, keys6(8'h4F, 8'h50, 8'h51, 8'h52, 8'h58, 8'h46));
		send_report(4'd8, 8'h00, keys6(8'h29, 8'h2C, 8'h28, 8'h39, 8'h45, 8'h44));
		send_report(4'd9, 8'h81, keys6(8'h80, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00));
		gen_mods = board.held_mods;
		gen_keys = board.held_keys;

		for (int n = 0; n < 443; n++) begin
			// sink stalls long while reports keep coming
			if (n == 120)
				hold_request = 1'b1;
			// source stops until the core has nothing left to send
			if (n == 250)
				wait_drained();
			// closing stretch at full rate on both sides
			if (n == 380) begin
				src_jitter = 1'b0;
				sink_jitter = 1'b0;
			end
			random_report();
		end

		wait_drained();
		repeat (60) @(posedge clk);

		$display("ran %0d reports: %0d kept, %0d dropped as short or rollover",
			board.reports_kept + board.reports_dropped, board.reports_kept,
			board.reports_dropped);
		$display("compared %0d set 1 words across idle bursts, a long sink hold and a drain",
			board.words_checked);
		if (board.failures == 0 && board.expected_words.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
